[rtl/assert_macros.svh]
// assertion macros used by the checker file
// clocked on clk, disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// signal keeps its value in the cycle after the condition
`define ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> $stable(sig)) else $error(msg);

`endif

[rtl/ccm_pkg.sv]
// shared types, keyword tables and token functions for the content coding matcher
// no dependencies
`timescale 1ns / 1ps

package ccm_pkg;

	localparam int KW_COUNT = 6;
	localparam int KW_MAX_LEN = 10;

	localparam logic [KW_COUNT-1:0] KW_ALL = '1;
	localparam logic [3:0] LEN_SAT = 4'd11;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// keyword text, first character in the top byte, padded with dots
	typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"deflate...",
		"gzip......",
		"compress..",
		"bzip2.....",
		"x-gzip....",
		"x-compress"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd7, 4'd4, 4'd8, 4'd5, 4'd6, 4'd10};

	// bit0 deflate, bit1 gzip, bit2 compress, bit3 bzip2
	localparam logic [3:0] KW_BIT [KW_COUNT] = '{
		4'b0001, 4'b0010, 4'b0100, 4'b1000, 4'b0010, 4'b0100
	};

	typedef struct packed {
		logic                at_start;
		logic [3:0]          tok_len;
		logic [KW_COUNT-1:0] alive;
		logic [3:0]          mask;
		logic                ended;
	} ccm_state_t;

	typedef struct packed {
		ccm_state_t next;
		logic       emit;
		logic [3:0] mask;
	} ccm_step_t;

	localparam ccm_state_t STATE_RESET = '{
		at_start: 1'b1,
		tok_len:  4'd0,
		alive:    KW_ALL,
		mask:     4'd0,
		ended:    1'b0
	};

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]})
			r = c + 8'h20;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {CHAR_SPACE, [8'h09:8'h0D]});
	endfunction

	// close the open token: add matching codings and start a fresh token
	function automatic ccm_state_t token_finish(input ccm_state_t st);
		ccm_state_t r;
		r = st;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (st.alive[k] && st.tok_len == KW_LEN[k])
				r.mask = r.mask | KW_BIT[k];
		end
		r.at_start = 1'b1;
		r.tok_len = 4'd0;
		r.alive = KW_ALL;
		return r;
	endfunction

endpackage

[rtl/ccm_step.sv]
// next-state logic for one header byte: separator, whitespace skip, keyword compare
// depends on ccm_pkg
`timescale 1ns / 1ps

module ccm_step import ccm_pkg::*; (
	input  ccm_state_t cur,
	input  logic [7:0] char_byte,
	input  logic       last,
	output ccm_step_t  res
);

	logic [7:0] lc;
	logic       ws;
	logic [3:0] pos;
	ccm_state_t mid;
	ccm_state_t closed;

	always_comb begin
		lc = fold_case(char_byte);
		ws = is_space(char_byte);
		pos = 4'(KW_MAX_LEN - 1) - cur.tok_len;
		mid = cur;
		if (!cur.ended) begin
			if (char_byte == CHAR_NUL) begin
				mid = token_finish(cur);
				mid.ended = 1'b1;
			end else if (char_byte == CHAR_COMMA) begin
				mid = token_finish(cur);
			end else if (cur.at_start && ws) begin
				mid = cur;
			end else begin
				mid.at_start = 1'b0;
				for (int k = 0; k < KW_COUNT; k++) begin
					if (cur.tok_len >= KW_LEN[k]) begin
						mid.alive[k] = 1'b0;
					end else if (KW_TEXT[k][pos] != lc) begin
						mid.alive[k] = 1'b0;
					end
				end
				if (cur.tok_len < LEN_SAT)
					mid.tok_len = cur.tok_len + 4'd1;
			end
		end

		// a last byte without a terminating zero closes the open token
		closed = token_finish(mid);
		res.emit = last;
		res.mask = mid.ended ? mid.mask : closed.mask;
		res.next = last ? STATE_RESET : mid;
	end

endmodule

[rtl/content_coding_list_matcher.sv]
// Content coding list matcher
// Input channel: byte_valid / byte_ready carry one header byte (char_byte) and
// last, which marks the final byte of a value. Output channel: mask_valid /
// mask_ready carry coding_mask, one transaction per value, issued for the byte
// marked last. bit0 deflate, bit1 gzip or x-gzip, bit2 compress or x-compress,
// bit3 bzip2.
// Path: a last byte passes the input register, then the output register.
// Throughput: one byte per cycle while no last byte is stalled; the input register
// feeds the keyword compare and token state update, which load the output register.
// Reset: arst_n clears the token state, the collected mask and both valids;
// the block takes a byte in the first cycle after reset.
// Stall: while a mask waits in the output register, bytes that are not last
// keep flowing; a last byte waits in the input register until the output frees,
// and byte_ready stays low for as long as it waits.
// depends on ccm_pkg and ccm_step
`timescale 1ns / 1ps

module content_coding_list_matcher import ccm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] char_byte,
	input  logic       last,
	output logic       mask_valid,
	input  logic       mask_ready,
	output logic [3:0] coding_mask
);

	logic       valid_s1;
	logic [7:0] char_byte_s1;
	logic       last_s1;
	logic       valid_s2;
	logic [3:0] coding_mask_s2;
	ccm_state_t state_q;
	ccm_step_t  step;
	logic       fire_s1;

	ccm_step u_step (
		.cur       (state_q),
		.char_byte (char_byte_s1),
		.last      (last_s1),
		.res       (step)
	);

	// a byte that emits needs a free output register
	assign fire_s1 = valid_s1 && (!step.emit || !valid_s2 || mask_ready);
	assign byte_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			char_byte_s1 <= char_byte;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (fire_s1) begin
			state_q <= step.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && step.emit) begin
			valid_s2 <= 1'b1;
		end else if (mask_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step.emit) begin
			coding_mask_s2 <= step.mask;
		end
	end

	assign mask_valid = valid_s2;
	assign coding_mask = coding_mask_s2;

endmodule

[rtl/ccm_checker.sv]
// port-level checks for the content coding matcher, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] char_byte,
	input logic       last,
	input logic       mask_valid,
	input logic       mask_ready,
	input logic [3:0] coding_mask
);

	// a stalled mask keeps its value
	`ASSERT_HOLD(a_mask_hold, mask_valid && !mask_ready, coding_mask, "mask changed while stalled")

	// with the output register empty the input side never stalls
	`ASSERT_CLK(a_ready_free, !mask_valid |-> byte_ready, "input stalled with output empty")

	// a stalled mask stays offered
	`ASSERT_HOLD(a_valid_hold, mask_valid && !mask_ready, mask_valid, "mask valid dropped while stalled")

	// nothing leaves right after reset
	`ASSERT_CLK(a_reset_idle, $rose(arst_n) |-> !mask_valid, "mask valid out of reset")

endmodule

bind content_coding_list_matcher ccm_checker u_ccm_checker (.*);

[dv/tb_top.sv]
// testbench for content_coding_list_matcher: directed byte table, then random header values
// scored against a behavioral matcher model; depends only on the rtl of the block
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TOTAL_ITEMS = 424;
	localparam int CALM_AFTER = 360;
	localparam int HOLD_AT = 120;
	localparam int PAUSE_AT = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int DIR_N = 24;

	localparam logic [3:0] MASK_NONE = 4'b0000;
	localparam logic [3:0] MASK_DEFLATE = 4'b0001;
	localparam logic [3:0] MASK_GZIP = 4'b0010;
	localparam logic [3:0] MASK_COMPRESS = 4'b0100;
	localparam logic [3:0] MASK_BZIP2 = 4'b1000;

	localparam logic [7:0] NUL = 8'h00;
	localparam logic [7:0] COMMA = 8'h2C;
	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [3:0] TOKEN_LEN_CAP = 4'd11;

	typedef enum int {
		KW_DEFLATE, KW_GZIP, KW_COMPRESS, KW_BZIP2, KW_X_GZIP, KW_X_COMPRESS, KW_COUNT
	} keyword_e;

	typedef struct packed {
		logic [7:0] chr;
		logic       fin;
		logic       has_mask;
		logic [3:0] mask;
	} dir_row_t;

	// has_mask rows carry a hand-written mask, the rest are scored by the model
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{NUL,  1'b1, 1'b1, MASK_NONE},
		'{" ",  1'b0, 1'b0, MASK_NONE},
		'{"G",  1'b0, 1'b0, MASK_NONE},
		'{"Z",  1'b0, 1'b0, MASK_NONE},
		'{"i",  1'b0, 1'b0, MASK_NONE},
		'{"P",  1'b1, 1'b1, MASK_GZIP},
		'{8'hFF, 1'b1, 1'b1, MASK_NONE},
		'{"b",  1'b0, 1'b0, MASK_NONE},
		'{"z",  1'b0, 1'b0, MASK_NONE},
		'{"i",  1'b0, 1'b0, MASK_NONE},
		'{"p",  1'b0, 1'b0, MASK_NONE},
		'{"2",  1'b0, 1'b0, MASK_NONE},
		'{" ",  1'b0, 1'b0, MASK_NONE},
		'{",",  1'b0, 1'b0, MASK_NONE},
		'{NUL,  1'b1, 1'b1, MASK_NONE},
		'{"d",  1'b0, 1'b0, MASK_NONE},
		'{"e",  1'b0, 1'b0, MASK_NONE},
		'{"f",  1'b0, 1'b0, MASK_NONE},
		'{"l",  1'b0, 1'b0, MASK_NONE},
		'{"a",  1'b0, 1'b0, MASK_NONE},
		'{"t",  1'b0, 1'b0, MASK_NONE},
		'{"e",  1'b0, 1'b0, MASK_NONE},
		'{NUL,  1'b0, 1'b0, MASK_NONE},
		'{"x",  1'b1, 1'b1, MASK_DEFLATE}
	};

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	logic [7:0] char_byte;
	logic       last;
	logic       mask_valid;
	logic       mask_ready;
	logic [3:0] coding_mask;

	// matcher model state
	logic       tok_at_start;
	logic [3:0] tok_len;
	logic [5:0] kw_live;
	logic [3:0] mask_acc;
	logic       val_done;

	logic [3:0] expected_masks [$];
	logic [7:0] value_bytes [$];
	logic [3:0] mask_want;
	int         mismatch_count = 0;
	int         items_sent = 0;
	int         cycle_count = 0;
	bit         calm_phase = 0;
	bit         sink_hold_req = 0;
	bit         sink_held = 0;
	bit         hold_done = 0;
	bit         pause_done = 0;

	content_coding_list_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.char_byte(char_byte),
		.last(last),
		.mask_valid(mask_valid),
		.mask_ready(mask_ready),
		.coding_mask(coding_mask)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	function automatic string keyword_text(input int k);
		case (k)
			KW_DEFLATE:    return "deflate";
			KW_GZIP:       return "gzip";
			KW_COMPRESS:   return "compress";
			KW_BZIP2:      return "bzip2";
			KW_X_GZIP:     return "x-gzip";
			KW_X_COMPRESS: return "x-compress";
			default:       return "";
		endcase
	endfunction

	function automatic logic [3:0] keyword_bit(input int k);
		case (k)
			KW_DEFLATE:    return MASK_DEFLATE;
			KW_GZIP:       return MASK_GZIP;
			KW_COMPRESS:   return MASK_COMPRESS;
			KW_BZIP2:      return MASK_BZIP2;
			KW_X_GZIP:     return MASK_GZIP;
			KW_X_COMPRESS: return MASK_COMPRESS;
			default:       return MASK_NONE;
		endcase
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] random_space();
		int p;
		p = $urandom_range(0, 5);
		return (p == 5) ? SPACE : 8'h09 + p[7:0];
	endfunction

	task automatic matcher_reset();
		tok_at_start = 1'b1;
		tok_len = 4'd0;
		kw_live = '1;
		mask_acc = MASK_NONE;
		val_done = 1'b0;
	endtask

	task automatic close_token();
		string s;
		for (int k = 0; k < KW_COUNT; k++) begin
			s = keyword_text(k);
			if (kw_live[k] && tok_len == s.len())
				mask_acc = mask_acc | keyword_bit(k);
		end
		tok_at_start = 1'b1;
		tok_len = 4'd0;
		kw_live = '1;
	endtask

	task automatic take_token_byte(input logic [7:0] c);
		logic [7:0] lc;
		string s;
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		tok_at_start = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (kw_live[k]) begin
				s = keyword_text(k);
				if (tok_len >= s.len() || s[tok_len] != lc)
					kw_live[k] = 1'b0;
			end
		end
		if (tok_len < TOKEN_LEN_CAP)
			tok_len = tok_len + 4'd1;
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic fin, output logic emit,
			output logic [3:0] m);
		emit = 1'b0;
		m = MASK_NONE;
		if (!val_done) begin
			if (c == NUL) begin
				close_token();
				val_done = 1'b1;
			end else if (c == COMMA) begin
				close_token();
			end else if (!(tok_at_start && is_ws(c))) begin
				take_token_byte(c);
			end
		end
		if (fin) begin
			if (!val_done)
				close_token();
			emit = 1'b1;
			m = mask_acc;
			matcher_reset();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [3:0] got,
			input logic [3:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic fin, input logic has_mask,
			input logic [3:0] fixed_mask);
		logic emit;
		logic [3:0] m;
		byte_valid <= 1'b1;
		char_byte <= c;
		last <= fin;
		do @(posedge clk); while (!byte_ready);
		scan_byte(c, fin, emit, m);
		if (emit)
			expected_masks.push_back(has_mask ? fixed_mask : m);
		items_sent++;
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// one header value: mostly well-formed token lists, some raw noise
	task automatic fill_value();
		int ntok;
		int pick;
		int n;
		string s;
		logic [7:0] c;
		value_bytes.delete();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 8)) value_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		ntok = $urandom_range(1, 4);
		for (int t = 0; t < ntok; t++) begin
			if (t > 0)
				value_bytes.push_back(COMMA);
			repeat ($urandom_range(0, 2)) value_bytes.push_back(random_space());
			pick = $urandom_range(0, 9);
			s = "";
			if (pick <= 5) begin
				s = keyword_text($urandom_range(0, KW_COUNT - 1));
			end else if (pick == 6) begin
				s = "identity";
			end else if (pick == 7) begin
				// unknown word, long ones past the length cap included
				n = $urandom_range(1, 14);
				repeat (n) value_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
			end else if (pick == 9) begin
				// near miss: one byte short or one byte too many
				s = keyword_text($urandom_range(0, KW_COUNT - 1));
				if ($urandom_range(0, 1))
					s = s.substr(0, s.len() - 2);
				else
					s = {s, "s"};
			end
			for (int i = 0; i < s.len(); i++) begin
				c = s[i];
				if (c >= "a" && c <= "z" && $urandom_range(0, 1))
					c = c - 8'h20;
				value_bytes.push_back(c);
			end
			if ($urandom_range(0, 5) == 0)
				value_bytes.push_back(random_space());
		end
		case ($urandom_range(0, 3))
			0: if (value_bytes.size() == 0) value_bytes.push_back("q");
			1: value_bytes.push_back(NUL);
			2: begin
				value_bytes.push_back(NUL);
				repeat ($urandom_range(1, 3)) value_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: value_bytes.push_back(COMMA);
		endcase
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL content_coding_list_matcher");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && mask_valid && mask_ready) begin
			if (expected_masks.size() == 0) begin
				report_mismatch("unexpected transaction", coding_mask, MASK_NONE);
			end else begin
				mask_want = expected_masks.pop_front();
				if (coding_mask !== mask_want)
					report_mismatch("coding_mask", coding_mask, mask_want);
			end
		end
	end

	// result side: random back-pressure, one long hold on request
	initial begin
		mask_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req && !sink_held) begin
				mask_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_held = 1;
			end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
				mask_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				mask_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		char_byte = NUL;
		last = 1'b0;
		matcher_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_byte(DIR_ROWS[i].chr, DIR_ROWS[i].fin, DIR_ROWS[i].has_mask, DIR_ROWS[i].mask);

		while (items_sent < TOTAL_ITEMS) begin
			calm_phase = (items_sent >= CALM_AFTER);
			if (!hold_done && items_sent >= HOLD_AT) begin
				sink_hold_req = 1;
				hold_done = 1;
			end
			if (!pause_done && items_sent >= PAUSE_AT) begin
				byte_valid <= 1'b0;
				while (expected_masks.size() != 0) @(posedge clk);
				pause_done = 1;
			end
			fill_value();
			for (int i = 0; i < value_bytes.size(); i++)
				send_byte(value_bytes[i], i == value_bytes.size() - 1, 1'b0, MASK_NONE);
		end
		byte_valid <= 1'b0;

		while (expected_masks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS content_coding_list_matcher");
		else
			$display("FAIL content_coding_list_matcher");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/ccm_pkg.sv
rtl/ccm_step.sv
rtl/content_coding_list_matcher.sv
rtl/ccm_checker.sv
dv/tb_top.sv
